### src/packet_buffer_tail_drop_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet buffer tail drop scheduler.
// ---------------------------------------------------------------------------
`ifndef PACKET_BUFFER_TAIL_DROP_SCHEDULER_ASSERT_SVH
`define PACKET_BUFFER_TAIL_DROP_SCHEDULER_ASSERT_SVH

// Implication or condition checked at every rising clock edge outside reset.
`define PBTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition checked at every rising clock edge, reset included.
`define PBTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/pbtd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbtd_pkg
// Shared types and constants of the packet buffer tail drop scheduler.
// ---------------------------------------------------------------------------
package pbtd_pkg;

    localparam int TIME_W        = 31;
    localparam int FIN_W         = 32;
    localparam int CAP_W         = 5;
    localparam int DEF_MAX_DEPTH = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [FIN_W-1:0] FIN_MAX   = 32'hFFFF_FFFF;

    // Control handed to every cell of the queue.
    typedef struct packed {
        logic retire;   // drop entries that finish at or before the arrival
        logic shift;    // move every entry one cell toward the old end
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RETIRE = 3'b010,
        S_ENQ    = 3'b100
    } t_state;

endpackage

### src/pbtd_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbtd_cell
// One slot of the finish time queue: holds a finish time and a valid bit.
// ---------------------------------------------------------------------------
module pbtd_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pbtd_pkg::t_cell_ctrl        i_ctrl,
    input  logic [pbtd_pkg::TIME_W-1:0] i_arrival,
    input  logic [pbtd_pkg::FIN_W-1:0]  i_prev_value,
    input  logic                        i_prev_valid,
    output logic [pbtd_pkg::FIN_W-1:0]  o_value,
    output logic                        o_valid
);

    logic [pbtd_pkg::FIN_W-1:0] r_value;
    logic                       r_valid;
    logic                       n_valid;
    logic                       w_done;

    // An entry whose finish time is not later than the arrival is retired.
    assign w_done = (r_value <= pbtd_pkg::FIN_W'(i_arrival));

    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_valid = i_prev_valid;
        end else if (i_ctrl.retire) begin
            n_valid = r_valid && !w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_prev_value;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

### src/packet_buffer_tail_drop_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_buffer_tail_drop_scheduler
// Single-server packet buffer with tail drop, built as a chain of queue cells.
// ---------------------------------------------------------------------------
// Usage:
// Packets arrive on the input channel (i_in_valid / o_in_ready) with their
// arrival and processing times. Each packet yields exactly one result on the
// output channel (o_out_valid / i_out_ready): a dropped flag and the time at
// which service begins (zero for a dropped packet).
// The capacity register is written through its own channel (i_cfg_valid /
// o_cfg_ready), which is always ready; write it only while the block is idle.
// After its transfer, a packet goes through a retire step, in which every
// cell retires its entry in parallel if that entry finishes by the arrival
// time, and then an enqueue step, in which the drop decision, the saturating
// finish-time add and the shift of the chain happen and the result enters
// the output register. A new packet is taken in that enqueue step as the
// previous one commits; the cell chain's retire/enqueue pair paces the input.
// The result sits in an output register. If the receiver stalls, the block
// finishes the retire step of the next packet and then waits in its enqueue
// step until the output register frees up; no input is taken meanwhile.
// Reset empties the queue (all cell valid bits clear) and sets the capacity
// to 16. Cell 0 holds the newest finish time; older entries sit further out.
// ---------------------------------------------------------------------------
`include "packet_buffer_tail_drop_scheduler_assert.svh"

module packet_buffer_tail_drop_scheduler #(
    parameter int MAX_DEPTH = pbtd_pkg::DEF_MAX_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pbtd_pkg::TIME_W-1:0] i_arrival,
    input  logic [pbtd_pkg::TIME_W-1:0] i_service,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_dropped,
    output logic [pbtd_pkg::FIN_W-1:0]  o_start,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pbtd_pkg::CAP_W-1:0]  i_cfg_capacity
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    pbtd_pkg::t_state r_state;
    pbtd_pkg::t_state n_state;

    logic [pbtd_pkg::CAP_W-1:0]  r_capacity;
    logic [pbtd_pkg::TIME_W-1:0] r_arrival;
    logic [pbtd_pkg::TIME_W-1:0] r_process;

    logic                        r_out_valid;
    logic                        r_dropped;
    logic [pbtd_pkg::FIN_W-1:0]  r_start;

    logic                        w_in_xfer;
    logic                        w_out_free;
    logic                        w_commit;
    logic                        w_full;
    logic                        w_drop;
    logic [8:0]                  w_cap_m1;
    logic [pbtd_pkg::FIN_W-1:0]  w_start;
    logic [pbtd_pkg::FIN_W:0]    w_sum;
    logic [pbtd_pkg::FIN_W-1:0]  w_finish;
    logic [MAX_DEPTH:0]          w_valid_plus1;

    pbtd_pkg::t_cell_ctrl        w_ctrl;

    logic [pbtd_pkg::FIN_W-1:0]  w_value [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]        w_valid;

    // Configuration port: always ready, capacity updated on every transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= pbtd_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    // The output register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == pbtd_pkg::S_ENQ) && w_out_free;
    assign o_in_ready = (r_state == pbtd_pkg::S_IDLE) || w_commit;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbtd_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = pbtd_pkg::S_RETIRE;
                end
            end
            pbtd_pkg::S_RETIRE: begin
                n_state = pbtd_pkg::S_ENQ;
            end
            pbtd_pkg::S_ENQ: begin
                if (w_commit) begin
                    n_state = w_in_xfer ? pbtd_pkg::S_RETIRE : pbtd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbtd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbtd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_arrival <= i_arrival;
            r_process <= i_service;
        end
    end

    // Valid entries always fill cells 0 up to count-1, so the queue holds at
    // least capacity entries exactly when the cell at capacity-1 is valid.
    // A capacity beyond the depth acts as the depth.
    assign w_cap_m1 = 9'(r_capacity) - 9'd1;

    always_comb begin
        if (r_capacity == '0) begin
            w_full = 1'b1;
        end else if (32'(r_capacity) > MAX_DEPTH) begin
            w_full = w_valid[MAX_DEPTH-1];
        end else begin
            w_full = w_valid[w_cap_m1[IDX_W-1:0]];
        end
    end

    assign w_drop = w_full;

    // Start after the newest queued packet, or at arrival when the queue is
    // empty. The finish time saturates at the largest 32-bit value.
    assign w_start  = w_valid[0] ? w_value[0] : pbtd_pkg::FIN_W'(r_arrival);
    assign w_sum    = (pbtd_pkg::FIN_W + 1)'(w_start)
                    + (pbtd_pkg::FIN_W + 1)'(r_process);
    assign w_finish = w_sum[pbtd_pkg::FIN_W] ? pbtd_pkg::FIN_MAX
                                             : w_sum[pbtd_pkg::FIN_W-1:0];

    assign w_ctrl.retire = (r_state == pbtd_pkg::S_RETIRE);
    assign w_ctrl.shift  = w_commit && !w_drop;

    // Chain of cells: cell 0 takes the new finish time, each other cell takes
    // the entry of its younger neighbor on a shift.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            pbtd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_arrival    (r_arrival),
                .i_prev_value (w_finish),
                .i_prev_valid (1'b1),
                .o_value      (w_value[g]),
                .o_valid      (w_valid[g])
            );
        end else begin : g_body
            pbtd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_arrival    (r_arrival),
                .i_prev_value (w_value[g-1]),
                .i_prev_valid (w_valid[g-1]),
                .o_value      (w_value[g]),
                .o_valid      (w_valid[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_dropped <= w_drop;
            r_start   <= w_drop ? '0 : w_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dropped   = r_dropped;
    assign o_start     = r_start;

    // Contiguous valid bits from cell 0 make valid + 1 a power of two.
    assign w_valid_plus1 = (MAX_DEPTH + 1)'(w_valid) + 1'b1;

    `PBTD_ASSERT(a_valid_contiguous, $onehot(w_valid_plus1), "queue cells not contiguous")
    `PBTD_ASSERT(a_no_overflow, w_ctrl.shift |-> !w_valid[MAX_DEPTH-1], "shift loses an entry")
    `PBTD_ASSERT(a_drop_zero, (r_out_valid && r_dropped) |-> (r_start == '0), "drop start")
    `PBTD_ASSERT_ALWAYS(a_retire_quiet, w_ctrl.retire |-> !w_ctrl.shift, "retire and shift")

endmodule

### sim/packet_buffer_tail_drop_scheduler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_buffer_tail_drop_scheduler_test
// Self-checking testbench for the tail drop packet scheduler. A queue-fed
// driver offers packets, a clocked monitor predicts each packet's start time
// or drop, and checks every result against those predictions in order.
// ---------------------------------------------------------------------------
module packet_buffer_tail_drop_scheduler_test;

    localparam int               DEPTH     = pbtd_pkg::DEF_MAX_DEPTH;
    localparam int               TIME_W    = pbtd_pkg::TIME_W;
    localparam int               FIN_W     = pbtd_pkg::FIN_W;
    localparam int               CAP_W     = pbtd_pkg::CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = pbtd_pkg::CAP_RESET;
    localparam logic [FIN_W-1:0] FIN_MAX   = pbtd_pkg::FIN_MAX;

    // One packet as offered on the input channel.
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
    } t_packet;

    // One scheduling decision as seen on the output channel.
    typedef struct packed {
        logic             dropped;
        logic [FIN_W-1:0] start;
    } t_sched_result;

    // DUT connections. Every input starts at a known value.
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [TIME_W-1:0] pkt_arrival  = '0;
    logic [TIME_W-1:0] pkt_service  = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic              dropped;
    logic [FIN_W-1:0]  res_start;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_capacity = '0;

    // Stimulus waiting for the driver, and the decisions still to be seen.
    t_packet       packets_to_send[$];
    t_sched_result predicted_results[$];

    // Private copy of the scheduler: the finish-time ring and the capacity.
    logic [FIN_W-1:0] finish_times [DEPTH];
    int               fin_head     = 0;
    int               fin_count    = 0;
    logic [CAP_W-1:0] capacity_reg = CAP_RESET;

    // Idling control. Percentages are set per phase by the stimulus block.
    int in_idle_pct   = 0;
    int out_idle_pct  = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    logic in_taken    = 1'b0;

    // Running totals for the summary and the verdict.
    int fail_count    = 0;
    int packets_sent  = 0;
    int results_seen  = 0;
    int drops_seen    = 0;
    int cap_writes    = 0;

    logic [TIME_W-1:0] arrival_base = '0;
    t_packet           accepted_pkt;
    t_sched_result     predicted;
    t_sched_result     oldest;
    t_packet           next_pkt;

    packet_buffer_tail_drop_scheduler dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_arrival      (pkt_arrival),
        .i_service      (pkt_service),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_dropped      (dropped),
        .o_start        (res_start),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity)
    );

    // 12 ns clock period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predict the decision for one accepted packet and advance the private
    // queue. Finished packets leave from the head first; a finish time equal
    // to the arrival counts as finished. A capacity above the ring depth
    // behaves as the depth, and an occupancy at or over the capacity drops.
    task automatic schedule_packet(input t_packet pkt, output t_sched_result res);
        logic [CAP_W-1:0] limit;
        logic [FIN_W-1:0] start;
        logic [FIN_W:0]   finish;
        limit = (capacity_reg > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity_reg;
        while (fin_count != 0 && finish_times[fin_head] <= {1'b0, pkt.arrival}) begin
            fin_head  = (fin_head + 1) % DEPTH;
            fin_count = fin_count - 1;
        end
        if (fin_count >= int'(limit)) begin
            res.dropped = 1'b1;
            res.start   = '0;
        end else begin
            if (fin_count == 0) begin
                start = {1'b0, pkt.arrival};
            end else begin
                start = finish_times[(fin_head + fin_count - 1) % DEPTH];
            end
            // The finish time saturates instead of wrapping.
            finish = {1'b0, start} + {2'b00, pkt.service};
            if (finish > {1'b0, FIN_MAX}) begin
                finish = {1'b0, FIN_MAX};
            end
            finish_times[(fin_head + fin_count) % DEPTH] = finish[FIN_W-1:0];
            fin_count   = fin_count + 1;
            res.dropped = 1'b0;
            res.start   = start;
        end
    endtask

    // Driver. Payload and valid change only at the falling edge. A new packet
    // is offered only once the previous transfer has completed, so valid and
    // the payload stay put while the DUT stalls its input.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (gap_left == 0 && in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
                gap_left = $urandom_range(1, 7);
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (packets_to_send.size() != 0) begin
                next_pkt = packets_to_send.pop_front();
                in_valid    <= 1'b1;
                pkt_arrival <= next_pkt.arrival;
                pkt_service <= next_pkt.service;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. A long hold-off is counted here in clock cycles whenever the
    // stimulus block asks for one; otherwise ready drops in short bursts.
    always @(negedge clk) begin
        if (holds_done != hold_requests) begin
            holds_done = holds_done + 1;
            hold_left  = 250;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
            // The current cycle opens a burst; stall_left counts the rest of it.
            stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor. Everything is sampled at the rising edge, before the DUT's own
    // updates of that edge take effect. Each input transfer adds a prediction
    // and each output transfer is checked against the oldest one.
    always @(posedge clk) begin
        in_taken = in_valid && in_ready;
        if (cfg_valid && cfg_ready) begin
            capacity_reg = cfg_capacity;
            cap_writes   = cap_writes + 1;
        end
        if (out_valid && out_ready) begin
            results_seen = results_seen + 1;
            if (predicted_results.size() == 0) begin
                $error("result transfer with no prediction pending: dropped %0d start %0d",
                       dropped, res_start);
                fail_count = fail_count + 1;
            end else begin
                oldest = predicted_results.pop_front();
                if (dropped !== oldest.dropped) begin
                    $error("dropped: expected %0d, actual %0d", oldest.dropped, dropped);
                    fail_count = fail_count + 1;
                end
                if (res_start !== oldest.start) begin
                    $error("start time: expected %0d, actual %0d", oldest.start, res_start);
                    fail_count = fail_count + 1;
                end
                if (oldest.dropped) begin
                    drops_seen = drops_seen + 1;
                end
            end
        end
        if (in_taken) begin
            accepted_pkt.arrival = pkt_arrival;
            accepted_pkt.service = pkt_service;
            schedule_packet(accepted_pkt, predicted);
            predicted_results.insert(predicted_results.size(), predicted);
            packets_sent = packets_sent + 1;
        end
    end

    task automatic send_packet(input logic [TIME_W-1:0] arrival,
                               input logic [TIME_W-1:0] service);
        t_packet pkt;
        pkt.arrival = arrival;
        pkt.service = service;
        packets_to_send.insert(packets_to_send.size(), pkt);
    endtask

    // Wait until every queued packet has been transferred and every decision
    // has come back, then let the pipeline settle.
    task automatic wait_until_idle();
        while (packets_to_send.size() != 0 || in_valid || predicted_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // The capacity register is written only when the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_valid    <= 1'b1;
        cfg_capacity <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: arrivals creep forward while service times
    // are on average longer than the gaps, so the buffer fills and drops.
    // Now and then the arrival jumps to a random point, which can go
    // backward. Finish times stay below the largest arrival so that the
    // queue keeps draining.
    task automatic queue_random_packets(input int count);
        int roll;
        logic [TIME_W-1:0] service;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                arrival_base = TIME_W'($urandom_range(0, 32'h7FFF_0000));
            end else begin
                arrival_base = arrival_base + TIME_W'($urandom_range(0, 12));
            end
            if ($urandom_range(0, 99) < 5) begin
                service = TIME_W'($urandom_range(0, 400));
            end else begin
                service = TIME_W'($urandom_range(0, 24));
            end
            send_packet(arrival_base, service);
        end
    endtask

    // Global watchdog, far above the slowest legal run.
    initial begin
        #4_800_000;
        $display("packet_buffer_tail_drop_scheduler regression: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int phase_caps [7];
        phase_caps = '{5'd1, 5'd31, 5'd5, 5'd17, 5'd0, 5'd8, 5'd16};
        phase_caps[4] = CAP_W'($urandom_range(0, 31));

        // Synchronous reset, released at a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset capacity of 16.
        in_idle_pct  = 20;
        out_idle_pct = 20;
        send_packet(0, 0);           // smallest fields on an empty queue
        send_packet(0, 5);           // zero-length entry retires at equal time
        send_packet(1, 5);           // starts at the previous finish
        send_packet(2, 0);           // zero service behind a busy server
        send_packet(5, 3);           // finish equal to arrival is retired
        send_packet(3, 1);           // arrival goes backward
        send_packet(14, 2);          // everything queued has finished
        // Fill the buffer to its capacity; the seventeenth packet is dropped.
        for (int n = 0; n < 17; n++) begin
            send_packet(20, 1);
        end

        // Capacity lowered while the buffer still holds entries.
        write_capacity(5'd2);
        send_packet(30, 1);
        // Zero capacity drops every packet.
        write_capacity(5'd0);
        send_packet(100, 7);
        send_packet(200, 7);
        arrival_base = 300;

        // Random phases, one capacity setting each.
        for (int p = 0; p < 7; p++) begin
            write_capacity(CAP_W'(phase_caps[p]));
            in_idle_pct  = (p % 3 == 0) ? 0 : 25;
            out_idle_pct = (p % 2 == 0) ? 30 : 10;
            queue_random_packets(125);
            if (p == 2) begin
                // Stop taking results for a long stretch while the driver
                // keeps offering, so the DUT backs up and stalls its input.
                hold_requests = hold_requests + 1;
            end
        end

        // Closing part without idling. Reaching the top of the time range
        // saturates finish times, which never retire again, so this runs last.
        write_capacity(5'd16);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_packet(31'h7FFF_FFFF, 0);            // retires the whole queue
        send_packet(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_packet(31'h7FFF_FFFF, 31'h7FFF_FFFF); // finish time saturates
        send_packet(31'h7FFF_FFFF, 31'h7FFF_FFFF); // starts at the maximum
        send_packet(0, 31'h7FFF_FFFF);
        for (int n = 0; n < 45; n++) begin
            send_packet(TIME_W'($urandom()), TIME_W'($urandom()));
        end

        wait_until_idle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d packets, %0d results, %0d of them dropped,",
                 packets_sent, results_seen, drops_seen);
        $display("across %0d capacity writes and one long receiver hold-off.", cap_writes);
        if (fail_count == 0) begin
            $display("packet_buffer_tail_drop_scheduler regression: pass");
        end else begin
            $display("packet_buffer_tail_drop_scheduler regression: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/pbtd_pkg.sv
src/pbtd_cell.sv
src/packet_buffer_tail_drop_scheduler.sv
sim/packet_buffer_tail_drop_scheduler_test.sv
